@@ design/cleb_pkg.sv @@
// Shared constants, key codes and controller/datapath interface types of the line editor.
package cleb_pkg;

  // Ring geometry: pointers carry one extra bit so that full and empty differ.
  localparam int BUFFER_DEPTH = 128;
  localparam int SLOT_W       = $clog2(BUFFER_DEPTH);
  localparam int PTR_W        = SLOT_W + 1;

  // Stream widths.
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;

  // Item kinds.
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Console modes.
  localparam logic MODE_EDIT = 1'b0;
  localparam logic MODE_RAW  = 1'b1;

  // Key codes.
  localparam logic [7:0] KEY_NUL    = 8'h00;
  localparam logic [7:0] KEY_CTRL_D = 8'h04;
  localparam logic [7:0] KEY_CTRL_H = 8'h08;
  localparam logic [7:0] KEY_LF     = 8'h0A;
  localparam logic [7:0] KEY_CR     = 8'h0D;
  localparam logic [7:0] KEY_CTRL_P = 8'h10;
  localparam logic [7:0] KEY_CTRL_U = 8'h15;
  localparam logic [7:0] KEY_RAW_K  = 8'h6B;
  localparam logic [7:0] KEY_DEL    = 8'h7F;
  localparam logic [7:0] KEY_UP     = 8'hE2;
  localparam logic [7:0] KEY_DOWN   = 8'hE3;
  localparam logic [7:0] KEY_LEFT   = 8'hE4;
  localparam logic [7:0] KEY_RIGHT  = 8'hE5;

  // Echo code that asks the display to erase one character.
  localparam logic [8:0] ECHO_ERASE = 9'h100;

  // Read status codes.
  localparam logic [1:0] READ_OK    = 2'd0;
  localparam logic [1:0] READ_EMPTY = 2'd1;
  localparam logic [1:0] READ_EOF   = 2'd2;

  // Which result the datapath forms when the controller finishes an item.
  typedef enum logic [1:0] {
    RES_KEY,
    RES_READ,
    RES_EMPTY,
    RES_KILL
  } res_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     accept;     // latch the incoming item and clear the erase count
    logic     kill_addr;  // read the store at the entry before the edit pointer
    logic     kill_step;  // step the edit pointer back by one erased character
    logic     finish;     // apply the item's updates and load the output register
    res_sel_t res_sel;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_read;
    logic is_kill;
    logic rd_empty;
    logic at_commit;
    logic mem_is_lf;
    logic out_free;
  } sts_t;

  // One result item.
  typedef struct packed {
    logic [8:0] echo_code;
    logic       echo_valid;
    logic [7:0] erase_count;
    logic       line_ready;
    logic       dump_request;
    logic [7:0] read_data;
    logic [1:0] read_status;
    logic       end_of_line;
  } res_t;

endpackage

@@ design/cleb_ctrl.sv @@
// Controller state machine that sequences key, read and kill-line items.
module cleb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  cleb_pkg::sts_t sts,
  output cleb_pkg::cmd_t cmd
);
  import cleb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_KILL_RD,
    S_KILL_CHK
  } state_t;

  state_t state;
  state_t state_next;

  // An item is taken only while the controller is idle.
  assign s_tready = (state == S_IDLE);

  // Command decode and next state.
  always_comb begin
    cmd        = '0;
    cmd.res_sel = RES_KEY;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.accept = s_tvalid;
        if (s_tvalid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_read) begin
          cmd.res_sel = sts.rd_empty ? RES_EMPTY : RES_READ;
          cmd.finish  = sts.out_free;
        end else if (sts.is_kill) begin
          state_next = S_KILL_RD;
        end else begin
          cmd.res_sel = RES_KEY;
          cmd.finish  = sts.out_free;
        end
        if (cmd.finish) begin
          state_next = S_IDLE;
        end
      end
      S_KILL_RD: begin
        if (sts.at_commit) begin
          cmd.res_sel = RES_KILL;
          cmd.finish  = sts.out_free;
          if (sts.out_free) begin
            state_next = S_IDLE;
          end
        end else begin
          cmd.kill_addr = 1'b1;
          state_next    = S_KILL_CHK;
        end
      end
      S_KILL_CHK: begin
        cmd.kill_addr = 1'b1;
        if (sts.mem_is_lf) begin
          cmd.res_sel = RES_KILL;
          cmd.finish  = sts.out_free;
          if (sts.out_free) begin
            state_next = S_IDLE;
          end
        end else begin
          cmd.kill_step = 1'b1;
          state_next    = S_KILL_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTH
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> sts.out_free)
    else $error("result loaded while the output register is occupied");
  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (state == S_IDLE))
    else $error("controller not idle after finishing an item");
  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> (state == S_DECODE))
    else $error("accepted item not decoded in the following cycle");
`endif

endmodule

@@ design/cleb_dp.sv @@
// Datapath: line store, ring pointers, item and mode registers and the output register.
module cleb_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic                            cfg_data,
  input  logic [cleb_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                            s_tuser,
  input  cleb_pkg::cmd_t                  cmd,
  output cleb_pkg::sts_t                  sts,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [cleb_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [1:0]                      m_tuser,
  output logic                            m_tlast
);
  import cleb_pkg::*;

  logic             console_mode;
  logic             item_op;
  logic [7:0]       item_key;
  logic             item_first;
  logic [PTR_W-1:0] read_ptr;
  logic [PTR_W-1:0] commit_ptr;
  logic [PTR_W-1:0] edit_ptr;
  logic [7:0]       kill_count;
  logic [7:0]       line_store [BUFFER_DEPTH];
  logic [7:0]       mem_q;
  logic [SLOT_W-1:0] rd_slot;
  logic             out_valid;
  res_t             out_res;

  logic [PTR_W-1:0] fill;
  logic [PTR_W-1:0] edit_inc;
  logic [PTR_W-1:0] edit_dec;
  logic             full;
  logic             full_after;
  logic             is_arrow;
  logic             is_raw_key;

  res_t             res_next;
  logic             store_en;
  logic [7:0]       store_byte;
  logic [PTR_W-1:0] read_next;
  logic [PTR_W-1:0] commit_next;
  logic [PTR_W-1:0] edit_next;

  // Ring arithmetic.
  assign fill       = edit_ptr - read_ptr;
  assign edit_inc   = edit_ptr + PTR_W'(1);
  assign edit_dec   = edit_ptr - PTR_W'(1);
  assign full       = (fill == PTR_W'(BUFFER_DEPTH));
  assign full_after = (fill == PTR_W'(BUFFER_DEPTH - 1));
  assign is_arrow   = (item_key == KEY_UP) || (item_key == KEY_DOWN) ||
                      (item_key == KEY_LEFT) || (item_key == KEY_RIGHT);
  assign is_raw_key = (item_key == KEY_UP) || (item_key == KEY_DOWN) ||
                      (item_key == KEY_RAW_K);

  // The store is read at the read pointer, or behind the edit pointer while killing a line.
  assign rd_slot = cmd.kill_addr ? edit_dec[SLOT_W-1:0] : read_ptr[SLOT_W-1:0];

  // Status towards the controller.
  assign sts.is_read   = (item_op == OP_READ);
  assign sts.is_kill   = (item_op == OP_KEY) && (console_mode == MODE_EDIT) &&
                         (item_key == KEY_CTRL_U);
  assign sts.rd_empty  = (read_ptr == commit_ptr);
  assign sts.at_commit = (edit_ptr == commit_ptr);
  assign sts.mem_is_lf = (mem_q == KEY_LF);
  assign sts.out_free  = !out_valid || m_tready;

  // Result and pointer updates of the item being finished.
  always_comb begin
    res_next    = '0;
    store_en    = 1'b0;
    store_byte  = item_key;
    read_next   = read_ptr;
    commit_next = commit_ptr;
    edit_next   = edit_ptr;
    unique case (cmd.res_sel)
      RES_KEY: begin
        if (console_mode == MODE_EDIT) begin
          if (item_key == KEY_CTRL_P) begin
            res_next.dump_request = 1'b1;
          end else if ((item_key == KEY_CTRL_H) || (item_key == KEY_DEL)) begin
            if (edit_ptr != commit_ptr) begin
              edit_next           = edit_dec;
              res_next.echo_code  = ECHO_ERASE;
              res_next.echo_valid = 1'b1;
            end
          end else if (is_arrow) begin
            res_next.echo_code  = {1'b0, item_key};
            res_next.echo_valid = 1'b1;
          end else if ((item_key != KEY_NUL) && !full) begin
            store_byte          = (item_key == KEY_CR) ? KEY_LF : item_key;
            store_en            = 1'b1;
            edit_next           = edit_inc;
            res_next.echo_code  = {1'b0, store_byte};
            res_next.echo_valid = 1'b1;
            if ((store_byte == KEY_LF) || (store_byte == KEY_CTRL_D) || full_after) begin
              commit_next         = edit_inc;
              res_next.line_ready = 1'b1;
            end
          end else begin
            store_en = 1'b0;
          end
        end else if (is_raw_key && !full) begin
          store_en            = 1'b1;
          edit_next           = edit_inc;
          commit_next         = edit_inc;
          res_next.line_ready = 1'b1;
        end else begin
          store_en = 1'b0;
        end
      end
      RES_READ: begin
        if (mem_q == KEY_CTRL_D) begin
          // End of file: the control-D is consumed only by the first byte of a request.
          if (item_first) begin
            read_next = read_ptr + PTR_W'(1);
          end
          res_next.read_status = READ_EOF;
        end else begin
          read_next            = read_ptr + PTR_W'(1);
          res_next.read_data   = mem_q;
          res_next.read_status = READ_OK;
          res_next.end_of_line = (mem_q == KEY_LF);
        end
      end
      RES_EMPTY: begin
        res_next.read_status = READ_EMPTY;
      end
      RES_KILL: begin
        res_next.erase_count = kill_count;
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  // Control registers: mode, pointers and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      console_mode <= MODE_EDIT;
      read_ptr     <= '0;
      commit_ptr   <= '0;
      edit_ptr     <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        console_mode <= cfg_data;
      end
      if (cmd.kill_step) begin
        edit_ptr <= edit_dec;
      end
      if (cmd.finish) begin
        read_ptr   <= read_next;
        commit_ptr <= commit_next;
        edit_ptr   <= edit_next;
        out_valid  <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: the item, the erase counter and the result.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_op    <= s_tuser;
      item_key   <= s_tdata[7:0];
      item_first <= s_tdata[8];
      kill_count <= '0;
    end else if (cmd.kill_step && (kill_count != 8'hFF)) begin
      kill_count <= kill_count + 8'd1;
    end
    if (cmd.finish) begin
      out_res <= res_next;
    end
  end

  // Line store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.finish && store_en) begin
      line_store[edit_ptr[SLOT_W-1:0]] <= store_byte;
    end
    mem_q <= line_store[rd_slot];
  end

  // Output stream packing.
  assign m_tvalid = out_valid;
  assign m_tdata  = {4'd0, out_res.read_data, out_res.dump_request, out_res.line_ready,
                     out_res.erase_count, out_res.echo_valid, out_res.echo_code};
  assign m_tuser  = out_res.read_status;
  assign m_tlast  = out_res.end_of_line;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= PTR_W'(BUFFER_DEPTH))
    else $error("ring holds more bytes than its depth");
  a_commit_order: assert property (@(posedge clk) disable iff (rst)
    (commit_ptr - read_ptr) <= fill)
    else $error("commit pointer lies outside the read and edit pointers");
  a_kill_stop: assert property (@(posedge clk) disable iff (rst)
    cmd.kill_step |-> (edit_ptr != commit_ptr))
    else $error("kill-line erased into committed text");
`endif

endmodule

@@ design/console_line_editor_buffer_core.sv @@
// Top level of the console line editor buffer: keyboard keys and reader requests in, one result out.
//
// Each input transfer is a key (tuser 0) or a one-byte read (tuser 1) and yields exactly one
// result transfer. An ordinary key or read is latched with the store entry at the read pointer
// when it is accepted, and the controller decides and updates the pointers in its decode
// state, waiting there while the output register is occupied. Control-U in edit mode steps
// back one erased character at a time, reading the entry behind the edit pointer through the
// store's registered read port before each step. The next item is accepted in the cycle after
// a result is loaded, while that result may still wait to be taken. The console mode register
// is written through the cfg channel, which is always ready and must only be used while idle.
module console_line_editor_buffer_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_data,   // console_mode
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [cleb_pkg::IN_DATA_W-1:0]  s_tdata,    // key_code[7:0], first_of_read[8]
  input  logic                            s_tuser,    // op
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [cleb_pkg::OUT_DATA_W-1:0] m_tdata,    // echo_code[8:0], echo_valid[9],
                                                      // erase_count[17:10], line_ready[18],
                                                      // dump_request[19], read_data[27:20]
  output logic [1:0]                      m_tuser,    // read_status
  output logic                            m_tlast     // end_of_line
);
  import cleb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The mode register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  // Sequencing of items.
  cleb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Store, pointers and result register.
  cleb_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule
